FILE: sv/bos_pkg.sv
// shared types and constants for the box overlap suppression block
package bos_pkg;

	localparam int MAX_BOXES   = 32;
	localparam int IDX_W       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int COORD_W     = 16;
	localparam int SIZE_W      = 15;
	localparam int EDGE_W      = COORD_W + 1;
	localparam int DIFF_W      = EDGE_W + 1;
	localparam int AREA_W      = 2 * SIZE_W;
	localparam int THR_W       = 31;
	localparam int OUT_IDX_W   = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	// input word
	typedef struct packed {
		logic signed [COORD_W-1:0] box_x;
		logic signed [COORD_W-1:0] box_y;
		logic [SIZE_W-1:0]         box_width;
		logic [SIZE_W-1:0]         box_height;
		logic                      box_alive;
		logic                      last_box;
	} box_in_t;

	// result word
	typedef struct packed {
		logic [OUT_IDX_W-1:0] box_index;
		logic                 keep;
		logic                 last_result;
	} box_out_t;

	// box geometry as held in the box memory
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [EDGE_W-1:0]  right;
		logic signed [EDGE_W-1:0]  bottom;
	} geom_t;

	// classified word passed from the front to the back
	typedef struct packed {
		geom_t geom;
		logic  alive;
		logic  last;
	} entry_t;

endpackage

FILE: sv/bos_front.sv
// front end: input register that takes box words and computes right and bottom edges
module bos_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            box_valid,
	output logic            box_ready,
	input  bos_pkg::box_in_t box_data,
	output logic            q_push,
	input  logic            q_full,
	output bos_pkg::entry_t q_data
);
	import bos_pkg::*;

	logic   v_q;
	entry_t ent_q;
	logic   take;

	// hold a word until the queue has room
	assign box_ready = !v_q || !q_full;
	assign take      = box_valid && box_ready;
	assign q_push    = v_q && !q_full;
	assign q_data    = ent_q;

	// word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= 1'b1;
		end else if (q_push) begin
			v_q <= 1'b0;
		end
	end

	// edges are x + width and y + height, one bit wider than the coordinates
	always_ff @(posedge clk) begin
		if (take) begin
			ent_q.geom.x      <= box_data.box_x;
			ent_q.geom.y      <= box_data.box_y;
			ent_q.geom.right  <= EDGE_W'(box_data.box_x) + $signed({2'b00, box_data.box_width});
			ent_q.geom.bottom <= EDGE_W'(box_data.box_y) + $signed({2'b00, box_data.box_height});
			ent_q.alive       <= box_data.box_alive;
			ent_q.last        <= box_data.last_box;
		end
	end

endmodule

FILE: sv/bos_queue.sv
// short queue of classified box words between the front and the back
module bos_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bos_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output bos_pkg::entry_t pop_data
);
	import bos_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/bos_back.sv
// back end: box memory, pairwise overlap sweep with one shared intersection unit, result output
module bos_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             q_pop,
	input  bos_pkg::entry_t  q_data,
	input  logic             cfg_we,
	input  logic [30:0]      cfg_wdata,
	output logic             result_valid,
	input  logic             result_ready,
	output bos_pkg::box_out_t result_data
);
	import bos_pkg::*;

	typedef enum logic [2:0] {
		LOAD,
		ROW,
		LATCH,
		SWEEP,
		DRAIN,
		EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  k_q;
	logic [THR_W-1:0]  thr_q;
	logic              res_v_q;
	box_out_t          res_q;

	geom_t             mem [MAX_BOXES];
	logic [MAX_BOXES-1:0] alive_q;
	geom_t             rd_q;
	geom_t             boxi_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_mem;

	logic              v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]  j_s1, j_s2, j_s3;
	logic [SIZE_W-1:0] sx_s2, sy_s2;
	logic              pos_s2;
	logic [AREA_W-1:0] area_s3;

	logic signed [COORD_W-1:0] left, top;
	logic signed [EDGE_W-1:0]  rmin, bmin;
	logic signed [DIFF_W-1:0]  sx, sy;
	logic              pos_x, pos_y;
	logic              hit;
	logic              emit_go;
	logic              k_last;

	assign q_pop        = (state_q == LOAD) && !q_empty;
	assign wr_mem       = q_pop && (count_q < CNT_W'(MAX_BOXES));
	assign rd_addr      = (state_q == ROW) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign result_valid = res_v_q;
	assign result_data  = res_q;
	assign emit_go      = (state_q == EMIT) && (!res_v_q || result_ready);
	assign k_last       = ((k_q + CNT_W'(1)) == count_q);

	// box memory: one write port for loading, one registered read port for the sweep
	always_ff @(posedge clk) begin
		if (wr_mem) begin
			mem[count_q[IDX_W-1:0]] <= q_data.geom;
		end
		rd_q <= mem[rd_addr];
		if (state_q == LATCH) begin
			boxi_q <= rd_q;
		end
	end

	// alive flags: set on load, cleared by a suppressing pair
	always_ff @(posedge clk) begin
		if (wr_mem) begin
			alive_q[count_q[IDX_W-1:0]] <= q_data.alive;
		end
		if (hit) begin
			alive_q[j_s3] <= 1'b0;
		end
	end

	// stage 2: overlap extents in x and y
	always_comb begin
		left  = (rd_q.x > boxi_q.x) ? rd_q.x : boxi_q.x;
		top   = (rd_q.y > boxi_q.y) ? rd_q.y : boxi_q.y;
		rmin  = (rd_q.right < boxi_q.right) ? rd_q.right : boxi_q.right;
		bmin  = (rd_q.bottom < boxi_q.bottom) ? rd_q.bottom : boxi_q.bottom;
		sx    = DIFF_W'(rmin) - DIFF_W'(left);
		sy    = DIFF_W'(bmin) - DIFF_W'(top);
		pos_x = !sx[DIFF_W-1] && (sx != '0);
		pos_y = !sy[DIFF_W-1] && (sy != '0);
	end

	// stage 4 compare against the threshold
	assign hit = v_s3 && ({{(THR_W - AREA_W){1'b0}}, area_s3} >= thr_q);

	// intersection pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == SWEEP) && (j_q != i_q);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// intersection pipeline data; positive extents never exceed the box size
	always_ff @(posedge clk) begin
		j_s1    <= j_q[IDX_W-1:0];
		j_s2    <= j_s1;
		sx_s2   <= sx[SIZE_W-1:0];
		sy_s2   <= sy[SIZE_W-1:0];
		pos_s2  <= pos_x && pos_y;
		j_s3    <= j_s2;
		area_s3 <= pos_s2 ? (AREA_W'(sx_s2) * AREA_W'(sy_s2)) : '0;
	end

	// sequencer, threshold register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			thr_q   <= THR_RESET;
			res_v_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (result_ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				LOAD: begin
					if (q_pop) begin
						if (wr_mem) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (q_data.last) begin
							i_q     <= '0;
							state_q <= ROW;
						end
					end
				end
				ROW: begin
					if (i_q == count_q) begin
						k_q     <= '0;
						state_q <= EMIT;
					end else if (alive_q[i_q[IDX_W-1:0]]) begin
						state_q <= LATCH;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				LATCH: begin
					j_q     <= '0;
					state_q <= SWEEP;
				end
				SWEEP: begin
					if ((j_q + CNT_W'(1)) == count_q) begin
						state_q <= DRAIN;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ROW;
					end
				end
				EMIT: begin
					if (emit_go) begin
						res_v_q           <= 1'b1;
						res_q.box_index   <= OUT_IDX_W'(k_q);
						res_q.keep        <= alive_q[k_q[IDX_W-1:0]];
						res_q.last_result <= k_last;
						if (k_last) begin
							count_q <= '0;
							state_q <= LOAD;
						end else begin
							k_q <= k_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= LOAD;
				end
			endcase
		end
	end

endmodule

FILE: sv/box_overlap_suppression.sv
// top level of the box overlap suppression block
// Boxes arrive on the box channel (box_valid/box_ready/box_data), sorted by
// falling score. Each accepted word is registered in the front end, gets its
// right and bottom edges computed and waits in a four-word queue. The back end
// stores up to MAX_BOXES boxes; extra boxes are dropped. A word marked
// last_box starts suppression: for each alive box i the back end sweeps all
// held boxes through one shared intersection unit (memory read, extents,
// multiply, compare), one pair per cycle, then drains that pipeline before the
// next row; dead rows are skipped. box_ready stays high while the queue has room,
// also while a set is being suppressed.
// Results leave on result_valid/result_ready/result_data, one word per box in
// index order, last_result on the final one. The output register holds a
// word while the receiver stalls, and emission pauses until it is taken.
// cfg_we writes cfg_wdata into the overlap threshold; write it only while idle.
// After reset the box set is empty, the queue is empty and the threshold is 1.
module box_overlap_suppression (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              box_valid,
	output logic              box_ready,
	input  bos_pkg::box_in_t  box_data,
	output logic              result_valid,
	input  logic              result_ready,
	output bos_pkg::box_out_t result_data,
	input  logic              cfg_we,
	input  logic [30:0]       cfg_wdata
);
	import bos_pkg::*;

	logic   q_push, q_full, q_pop, q_empty;
	entry_t q_in, q_out;

	// front end
	bos_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.box_data  (box_data),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_data    (q_in)
	);

	// queue between front and back
	bos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_out)
	);

	// back end
	bos_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_data       (q_out),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

FILE: sv/bos_checker.sv
// port-level checker for the box overlap suppression block, with its bind
module bos_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input bos_pkg::box_out_t result_data
);
	import bos_pkg::*;

	logic [OUT_IDX_W-1:0] exp_q;
	logic                 res_take;

	assign res_take = result_valid && result_ready;

	// next expected result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (res_take) begin
			exp_q <= result_data.last_result ? '0 : result_data.box_index + OUT_IDX_W'(1);
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result word changed while stalled");

	// results count up from zero within each set
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.box_index == exp_q)
		else $error("result index out of order");

	// a word that is not last leaves room for the next box
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.last_result |->
			({1'b0, result_data.box_index} + (OUT_IDX_W + 1)'(1)) < (OUT_IDX_W + 1)'(MAX_BOXES))
		else $error("set longer than the box memory");

endmodule

bind box_overlap_suppression bos_checker u_bos_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);
